[hw/rtl/oal_pkg.sv]
// shared types and constants of the ordered array list
package oal_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W = 32;
	localparam int POS_W = 7;
	localparam int LEN_W = 7;

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_GET    = 3'd2,
		REQ_LOCATE = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// what every cell of the row does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_ROT  = 2'd1,
		CELL_INS  = 2'd2,
		CELL_DEL  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic signed [VALUE_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		status_t status;
		logic signed [VALUE_W-1:0] value_out;
		logic [POS_W-1:0] found_position;
		logic [LEN_W-1:0] length_out;
	} result_t;

endpackage

[hw/rtl/ordered_array_list_unit.sv]
// top level of the ordered array list: request decode, scan control, result register
//
// A bounded list of up to CAPACITY signed 32-bit entries held in a ring of cells.
// Insert, clear, unused kinds and requests that fail their range or full check
// finish in the cycle they are accepted. For get, locate and delete, after the
// accepting cycle the whole ring rotates once through the head cell, which is the
// only place a value is read and compared, and delete then closes the gap in a
// shift state, in all cells at or past the position at once. A new request is taken
// whenever the controller is idle; a result that finds the output register still
// occupied waits in a hold register, which stalls the next request until it moves on.
module ordered_array_list_unit #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic [2:0] req_type,
	input  logic [oal_pkg::POS_W-1:0] position,
	input  logic signed [oal_pkg::VALUE_W-1:0] value,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [1:0] status,
	output logic signed [oal_pkg::VALUE_W-1:0] value_out,
	output logic [oal_pkg::POS_W-1:0] found_position,
	output logic [oal_pkg::LEN_W-1:0] length_out
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;
	localparam int FW = (IW + 1 > oal_pkg::POS_W) ? IW + 1 : oal_pkg::POS_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_HOLD  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [IW-1:0] scan_q;
	logic [IW-1:0] pidx_q;
	logic [IW-1:0] pidx;
	logic is_delete_q;
	logic is_locate_q;
	logic signed [oal_pkg::VALUE_W-1:0] key_q;
	logic signed [oal_pkg::VALUE_W-1:0] vout_q;
	logic signed [oal_pkg::VALUE_W-1:0] vout_n;
	logic [FW-1:0] found_q;
	logic [FW-1:0] found_n;
	logic hit_q;
	logic hit_n;

	oal_pkg::result_t res_d;
	oal_pkg::result_t hold_q;
	oal_pkg::result_t out_q;
	logic out_valid_q;
	logic fin;
	logic out_free;
	logic req_acc;

	oal_pkg::cell_ctl_t ctl;
	logic [IW-1:0] cell_pos;
	logic signed [oal_pkg::VALUE_W-1:0] head;

	logic [CMPW-1:0] pos_e;
	logic [CMPW-1:0] cnt_e;
	logic [CMPW-1:0] cnt_m1;
	logic [CMPW-1:0] pos_m1;
	logic [CMPW:0] cnt_p1;
	logic ins_bad;
	logic rd_bad;
	logic full;
	logic last_scan;

	assign req_stall = state_q != S_IDLE;
	assign req_acc = req_valid && !req_stall;
	assign out_free = !out_valid_q || !rsp_stall;

	assign pos_e = CMPW'(position);
	assign cnt_e = CMPW'(count_q);
	assign cnt_m1 = cnt_e - CMPW'(1);
	assign pos_m1 = pos_e - CMPW'(1);
	assign pidx = pos_m1[IW-1:0];
	assign cnt_p1 = (CMPW + 1)'(cnt_e) + (CMPW + 1)'(1);
	assign ins_bad = (pos_e == '0) || ((CMPW + 1)'(pos_e) > cnt_p1);
	assign rd_bad = (pos_e == '0) || (pos_e > cnt_e);
	assign full = count_q == CW'(CAPACITY);
	assign last_scan = scan_q == IW'(CAPACITY - 1);

	// head holds the entry at index scan_q while the ring turns
	always_comb begin
		hit_n = hit_q;
		found_n = found_q;
		vout_n = vout_q;
		if (is_locate_q) begin
			if (!hit_q && (CMPW'(scan_q) < cnt_e) && (head == key_q)) begin
				hit_n = 1'b1;
				found_n = FW'(scan_q) + FW'(1);
			end
		end else if (scan_q == pidx_q) begin
			vout_n = head;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		fin = 1'b0;
		ctl.op = oal_pkg::CELL_HOLD;
		ctl.value = value;
		cell_pos = pidx_q;
		res_d.status = oal_pkg::STAT_DONE;
		res_d.value_out = '0;
		res_d.found_position = '0;
		res_d.length_out = cnt_e[oal_pkg::LEN_W-1:0];
		case (state_q)
			S_IDLE: begin
				cell_pos = pidx;
				if (req_acc) begin
					case (req_type)
						oal_pkg::REQ_INSERT: begin
							fin = 1'b1;
							if (ins_bad) begin
								res_d.status = oal_pkg::STAT_RANGE;
							end else if (full) begin
								res_d.status = oal_pkg::STAT_FULL;
							end else begin
								ctl.op = oal_pkg::CELL_INS;
								count_d = count_q + CW'(1);
								res_d.length_out = cnt_p1[oal_pkg::LEN_W-1:0];
							end
						end
						oal_pkg::REQ_DELETE, oal_pkg::REQ_GET: begin
							if (rd_bad) begin
								fin = 1'b1;
								res_d.status = oal_pkg::STAT_RANGE;
							end else begin
								state_d = S_SCAN;
							end
						end
						oal_pkg::REQ_LOCATE: begin
							state_d = S_SCAN;
						end
						oal_pkg::REQ_CLEAR: begin
							fin = 1'b1;
							count_d = '0;
							res_d.length_out = '0;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				ctl.op = oal_pkg::CELL_ROT;
				if (last_scan) begin
					if (is_delete_q) begin
						state_d = S_SHIFT;
					end else begin
						fin = 1'b1;
						res_d.value_out = is_locate_q ? '0 : vout_n;
						res_d.found_position = found_n[oal_pkg::POS_W-1:0];
					end
				end
			end
			S_SHIFT: begin
				ctl.op = oal_pkg::CELL_DEL;
				fin = 1'b1;
				count_d = count_q - CW'(1);
				res_d.value_out = vout_q;
				res_d.length_out = cnt_m1[oal_pkg::LEN_W-1:0];
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if ((fin && out_free) || (state_q == S_HOLD && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			scan_q <= '0;
			pidx_q <= pidx;
			key_q <= value;
			is_delete_q <= req_type == oal_pkg::REQ_DELETE;
			is_locate_q <= req_type == oal_pkg::REQ_LOCATE;
			hit_q <= 1'b0;
			found_q <= '0;
			vout_q <= '0;
		end else if (state_q == S_SCAN) begin
			scan_q <= scan_q + IW'(1);
			hit_q <= hit_n;
			found_q <= found_n;
			vout_q <= vout_n;
		end
		if (fin && !out_free) begin
			hold_q <= res_d;
		end
		if (fin && out_free) begin
			out_q <= res_d;
		end else if (state_q == S_HOLD && out_free) begin
			out_q <= hold_q;
		end
	end

	oal_chain #(
		.CAPACITY(CAPACITY)
	) u_chain (
		.clk(clk),
		.ctl(ctl),
		.pos(cell_pos),
		.head(head)
	);

	assign rsp_valid = out_valid_q;
	assign status = out_q.status;
	assign value_out = out_q.value_out;
	assign found_position = out_q.found_position;
	assign length_out = out_q.length_out;

endmodule

[hw/rtl/oal_cell.sv]
// one list entry cell: holds, rotates, opens a gap or closes one
module oal_cell #(
	parameter int IW = 6,
	parameter int IDX = 0
) (
	input  logic clk,
	input  oal_pkg::cell_ctl_t ctl,
	input  logic [IW-1:0] pos,
	input  logic signed [oal_pkg::VALUE_W-1:0] left,
	input  logic signed [oal_pkg::VALUE_W-1:0] right,
	output logic signed [oal_pkg::VALUE_W-1:0] data
);

	logic signed [oal_pkg::VALUE_W-1:0] data_q;
	logic at_pos;
	logic past_pos;

	assign at_pos = IW'(IDX) == pos;
	assign past_pos = IW'(IDX) >= pos;

	always_ff @(posedge clk) begin
		case (ctl.op)
			oal_pkg::CELL_ROT: begin
				data_q <= right;
			end
			oal_pkg::CELL_INS: begin
				if (at_pos) begin
					data_q <= ctl.value;
				end else if (past_pos) begin
					data_q <= left;
				end
			end
			oal_pkg::CELL_DEL: begin
				if (past_pos) begin
					data_q <= right;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

[hw/rtl/oal_chain.sv]
// ring of entry cells, cell 0 is the head that control looks at
module oal_chain #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
	localparam int IW = $clog2(CAPACITY)
) (
	input  logic clk,
	input  oal_pkg::cell_ctl_t ctl,
	input  logic [IW-1:0] pos,
	output logic signed [oal_pkg::VALUE_W-1:0] head
);

	logic signed [oal_pkg::VALUE_W-1:0] cell_data [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		oal_cell #(
			.IW(IW),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.pos(pos),
			.left(cell_data[(i + CAPACITY - 1) % CAPACITY]),
			.right(cell_data[(i + 1) % CAPACITY]),
			.data(cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule
